// ===== sv/srp_pkg.sv =====
// Shared types and constants of the semicolon record parser.
// No dependencies; used by srp_rsp_buffer and semicolon_record_parser.
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam int unsigned MIN_NAME_LEN = 3;

   localparam logic [31:0] MAG_CAP = 32'h8000_0000;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_OVERSIZE = 3'd1;
   localparam logic [2:0] STATUS_NAME     = 3'd2;
   localparam logic [2:0] STATUS_EMPLOYEE = 3'd3;
   localparam logic [2:0] STATUS_JOB      = 3'd4;
   localparam logic [2:0] STATUS_COMPANY  = 3'd5;

   localparam logic KIND_ECHO    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // register index is paddr[2] (byte address 4*i)
   localparam logic       REG_MAX_LEN   = 1'b0;
   localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

   typedef enum logic [4:0] {
      FIELD_NAME     = 5'b00001,
      FIELD_EMPLOYEE = 5'b00010,
      FIELD_JOB      = 5'b00100,
      FIELD_COMPANY  = 5'b01000,
      FIELD_DONE     = 5'b10000
   } field_type;

   typedef enum logic [2:0] {
      PHASE_SKIP   = 3'b001,
      PHASE_DIGITS = 3'b010,
      PHASE_STOP   = 3'b100
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  name_char;
      logic [2:0]  status;
      logic [15:0] name_length;
      logic [31:0] employee_number;
      logic [31:0] job_number;
      logic [31:0] company_number;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/srp_rsp_buffer.sv =====
// Two-entry result buffer (output register plus skid register).
// Depends on srp_pkg for the result item type.
`timescale 1ns / 1ps
`default_nettype none

module srp_rsp_buffer (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire srp_pkg::rsp_type push_data,
   output logic                 full,
   output logic                 rsp_valid,
   output srp_pkg::rsp_type     rsp_data,
   input  wire logic            rsp_stall
);

   logic             main_valid_ff;
   logic             skid_valid_ff;
   srp_pkg::rsp_type main_ff;
   srp_pkg::rsp_type skid_ff;
   logic             take;

   assign take      = main_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (!main_valid_ff) begin
         main_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else begin
            main_ff <= push_data;
         end
      end else if (!main_valid_ff) begin
         main_ff <= push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/semicolon_record_parser.sv =====
// Top level of the semicolon record parser: field state, number reader, APB register.
// Depends on srp_pkg and srp_rsp_buffer.
`timescale 1ns / 1ps
`default_nettype none

// Parses name;number;number;number; records one byte per item, byte 0 ending a
// message. Every name byte is echoed and the terminator gives one summary with
// status, name length and the committed numbers. One item is taken per clock while
// req_stall is low, and each result is registered. A two-entry output buffer lets
// one more item in while a result waits; req_stall rises only when both entries
// hold results. max_message_length sits at byte address 0.
module semicolon_record_parser #(
   parameter int unsigned LENGTH_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_msg_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_name_char,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_name_length,
   output logic [31:0]      rsp_employee_number,
   output logic [31:0]      rsp_job_number,
   output logic [31:0]      rsp_company_number,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int unsigned MSG_BITS = LENGTH_BITS + 1;
   localparam int unsigned CMP_BITS = (MSG_BITS > 16) ? MSG_BITS : 16;
   localparam int unsigned NAME_CMP = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

   logic [15:0]            max_len_ff;
   srp_pkg::field_type     field_ff, field_in;
   logic [MSG_BITS-1:0]    msg_len_ff, msg_len_in;
   logic [LENGTH_BITS-1:0] name_cnt_ff, name_cnt_in;
   logic                   seen_ff, seen_in;
   srp_pkg::phase_type     phase_ff, phase_in;
   logic                   neg_ff, neg_in;
   logic [31:0]            acc_ff, acc_in;
   logic [31:0]            pend_ff [3];
   logic [31:0]            pend_in [3];
   logic [2:0]             pend_valid_ff, pend_valid_in;
   logic [2:0]             err_ff, err_in;
   logic [31:0]            commit_ff [3];
   logic [31:0]            commit_in [3];

   logic                   req_accept;
   logic                   cfg_write;
   logic                   buf_full;
   logic                   push;
   srp_pkg::rsp_type       push_data;
   srp_pkg::rsp_type       rsp_data;

   logic                   is_semi, is_digit, is_space, is_sign;
   logic [35:0]            acc_prod;
   logic [31:0]            acc_step;
   logic [31:0]            number_value;
   logic [1:0]             field_slot;
   logic [2:0]             field_err;
   srp_pkg::field_type     field_next;
   logic                   oversize;
   logic [2:0]             final_err;
   logic [15:0]            name_length;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = buf_full;
   assign pready     = 1'b1;
   assign cfg_write  = psel && penable && pwrite && pready && (paddr[2] == srp_pkg::REG_MAX_LEN);
   assign prdata     = (paddr[2] == srp_pkg::REG_MAX_LEN) ? {16'd0, max_len_ff} : 32'd0;

   assign is_semi  = req_msg_byte == srp_pkg::CHAR_SEMI;
   assign is_digit = (req_msg_byte >= srp_pkg::CHAR_ZERO) && (req_msg_byte <= srp_pkg::CHAR_NINE);
   assign is_space = (req_msg_byte == srp_pkg::CHAR_SPACE)
                  || ((req_msg_byte >= srp_pkg::CHAR_TAB) && (req_msg_byte <= srp_pkg::CHAR_CR));
   assign is_sign  = (req_msg_byte == srp_pkg::CHAR_PLUS) || (req_msg_byte == srp_pkg::CHAR_MINUS);

   assign acc_prod = ({4'd0, acc_ff} * 36'd10) + {32'd0, req_msg_byte[3:0]};
   assign acc_step = (acc_prod > {4'd0, srp_pkg::MAG_CAP}) ? srp_pkg::MAG_CAP : acc_prod[31:0];

   assign number_value = neg_ff ? (32'd0 - acc_ff)
                       : ((acc_ff > srp_pkg::POS_MAX) ? srp_pkg::POS_MAX : acc_ff);

   assign oversize = CMP_BITS'(msg_len_ff) > CMP_BITS'(max_len_ff);
   assign final_err = (err_ff != srp_pkg::STATUS_OK) ? err_ff : field_err;
   assign name_length = (NAME_CMP'(name_cnt_ff) > NAME_CMP'(16'hFFFF)) ? 16'hFFFF
                      : 16'(NAME_CMP'(name_cnt_ff));

   always_comb begin
      field_slot = 2'd0;
      field_err  = srp_pkg::STATUS_OK;
      field_next = srp_pkg::FIELD_DONE;
      unique case (field_ff)
         srp_pkg::FIELD_NAME: begin
            field_err  = srp_pkg::STATUS_NAME;
            field_next = srp_pkg::FIELD_EMPLOYEE;
         end
         srp_pkg::FIELD_EMPLOYEE: begin
            field_slot = 2'd0;
            field_err  = srp_pkg::STATUS_EMPLOYEE;
            field_next = srp_pkg::FIELD_JOB;
         end
         srp_pkg::FIELD_JOB: begin
            field_slot = 2'd1;
            field_err  = srp_pkg::STATUS_JOB;
            field_next = srp_pkg::FIELD_COMPANY;
         end
         srp_pkg::FIELD_COMPANY: begin
            field_slot = 2'd2;
            field_err  = srp_pkg::STATUS_COMPANY;
            field_next = srp_pkg::FIELD_DONE;
         end
         srp_pkg::FIELD_DONE: begin
            field_next = srp_pkg::FIELD_DONE;
         end
         default: begin
            field_next = srp_pkg::FIELD_DONE;
         end
      endcase
   end

   always_comb begin
      field_in      = field_ff;
      msg_len_in    = msg_len_ff;
      name_cnt_in   = name_cnt_ff;
      seen_in       = seen_ff;
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      err_in        = err_ff;
      commit_in     = commit_ff;
      push          = 1'b0;
      push_data     = '0;
      if (req_accept) begin
         if (req_msg_byte == srp_pkg::CHAR_NUL) begin
            for (int i = 0; i < 3; i++) begin
               if (!oversize && pend_valid_ff[i]) begin
                  commit_in[i] = pend_ff[i];
               end
            end
            push                      = 1'b1;
            push_data.kind            = srp_pkg::KIND_SUMMARY;
            push_data.status          = oversize ? srp_pkg::STATUS_OVERSIZE : final_err;
            push_data.name_length     = name_length;
            push_data.employee_number = commit_in[0];
            push_data.job_number      = commit_in[1];
            push_data.company_number  = commit_in[2];
            field_in      = srp_pkg::FIELD_NAME;
            msg_len_in    = '0;
            name_cnt_in   = '0;
            err_in        = srp_pkg::STATUS_OK;
            seen_in       = 1'b0;
            phase_in      = srp_pkg::PHASE_SKIP;
            neg_in        = 1'b0;
            acc_in        = '0;
            pend_valid_in = '0;
            for (int i = 0; i < 3; i++) begin
               pend_in[i] = '0;
            end
         end else begin
            if (msg_len_ff != '1) begin
               msg_len_in = msg_len_ff + 1'b1;
            end
            unique case (field_ff)
               srp_pkg::FIELD_NAME: begin
                  if (is_semi) begin
                     if ((name_cnt_ff < LENGTH_BITS'(srp_pkg::MIN_NAME_LEN))
                         && (err_ff == srp_pkg::STATUS_OK)) begin
                        err_in = srp_pkg::STATUS_NAME;
                     end
                     field_in = field_next;
                     seen_in  = 1'b0;
                     phase_in = srp_pkg::PHASE_SKIP;
                     neg_in   = 1'b0;
                     acc_in   = '0;
                  end else begin
                     if (name_cnt_ff != '1) begin
                        name_cnt_in = name_cnt_ff + 1'b1;
                     end
                     push                = 1'b1;
                     push_data.kind      = srp_pkg::KIND_ECHO;
                     push_data.name_char = req_msg_byte;
                  end
               end
               srp_pkg::FIELD_EMPLOYEE, srp_pkg::FIELD_JOB, srp_pkg::FIELD_COMPANY: begin
                  if (is_semi) begin
                     if (err_ff == srp_pkg::STATUS_OK) begin
                        if (!seen_ff) begin
                           err_in = field_err;
                        end else begin
                           pend_in[field_slot]       = number_value;
                           pend_valid_in[field_slot] = 1'b1;
                        end
                     end
                     field_in = field_next;
                     seen_in  = 1'b0;
                     phase_in = srp_pkg::PHASE_SKIP;
                     neg_in   = 1'b0;
                     acc_in   = '0;
                  end else begin
                     seen_in = 1'b1;
                     unique case (phase_ff)
                        srp_pkg::PHASE_SKIP: begin
                           if (is_space) begin
                              phase_in = srp_pkg::PHASE_SKIP;
                           end else if (is_sign) begin
                              neg_in   = req_msg_byte == srp_pkg::CHAR_MINUS;
                              phase_in = srp_pkg::PHASE_DIGITS;
                           end else if (is_digit) begin
                              phase_in = srp_pkg::PHASE_DIGITS;
                              acc_in   = acc_step;
                           end else begin
                              phase_in = srp_pkg::PHASE_STOP;
                           end
                        end
                        srp_pkg::PHASE_DIGITS: begin
                           if (is_digit) begin
                              acc_in = acc_step;
                           end else begin
                              phase_in = srp_pkg::PHASE_STOP;
                           end
                        end
                        srp_pkg::PHASE_STOP: begin
                           phase_in = srp_pkg::PHASE_STOP;
                        end
                        default: begin
                           phase_in = srp_pkg::PHASE_STOP;
                        end
                     endcase
                  end
               end
               srp_pkg::FIELD_DONE: begin
                  field_in = srp_pkg::FIELD_DONE;
               end
               default: begin
                  field_in = srp_pkg::FIELD_DONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= srp_pkg::MAX_LEN_RESET;
         field_ff      <= srp_pkg::FIELD_NAME;
         msg_len_ff    <= '0;
         name_cnt_ff   <= '0;
         seen_ff       <= 1'b0;
         phase_ff      <= srp_pkg::PHASE_SKIP;
         neg_ff        <= 1'b0;
         acc_ff        <= '0;
         pend_valid_ff <= '0;
         err_ff        <= srp_pkg::STATUS_OK;
         for (int i = 0; i < 3; i++) begin
            pend_ff[i]   <= '0;
            commit_ff[i] <= '0;
         end
      end else begin
         if (cfg_write) begin
            max_len_ff <= pwdata[15:0];
         end
         field_ff      <= field_in;
         msg_len_ff    <= msg_len_in;
         name_cnt_ff   <= name_cnt_in;
         seen_ff       <= seen_in;
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         acc_ff        <= acc_in;
         pend_valid_ff <= pend_valid_in;
         err_ff        <= err_in;
         pend_ff       <= pend_in;
         commit_ff     <= commit_in;
      end
   end

   srp_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   assign rsp_kind            = rsp_data.kind;
   assign rsp_name_char       = rsp_data.name_char;
   assign rsp_status          = rsp_data.status;
   assign rsp_name_length     = rsp_data.name_length;
   assign rsp_employee_number = rsp_data.employee_number;
   assign rsp_job_number      = rsp_data.job_number;
   assign rsp_company_number  = rsp_data.company_number;

   // skid entry only fills behind a held output entry
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("result buffer: skid entry held with output register empty");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_msg_byte == srp_pkg::CHAR_NUL)) |=> rsp_valid)
      else $error("terminator accepted but no summary pending");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == srp_pkg::KIND_ECHO))
         |-> ((rsp_status == srp_pkg::STATUS_OK) && (rsp_name_length == 16'd0)))
      else $error("echo item carries summary fields");

   assert property (@(posedge clock) disable iff (reset)
      (err_ff != srp_pkg::STATUS_OK) |-> (field_ff != srp_pkg::FIELD_NAME))
      else $error("field error recorded while still in name field");

endmodule

`default_nettype wire
